// File: sv/alc_pkg.sv
`timescale 1ns / 1ps

package alc_pkg;

    // request kinds as they arrive on the command port
    typedef enum logic [2:0] {
        K_READ    = 3'd0,
        K_FIND    = 3'd1,
        K_INSERT  = 3'd2,
        K_DELETE  = 3'd3,
        K_REPLACE = 3'd4
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    localparam int POS_BITS  = 7;
    localparam int VAL_BITS  = 32;
    localparam int FPOS_BITS = 6;

endpackage

// File: sv/alc_ram.sv
`timescale 1ns / 1ps

module alc_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/array_list_engine.sv
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------------
// command   | in        | start high, busy low | i_kind, i_position, i_value
// result    | out       | o_strobe, one cycle  | o_status, o_read_value, o_found_position,
//           |           |                      | o_count_after
//
// one result per command, strobed the cycle after the command finishes; replace and
// errors answer without a walk, read takes one ram read, find walks from the front,
// insert and delete walk between the position and the length, insert at the length
// itself walks nothing; the walks go one entry per cycle through the element ram
// reset clears the length and the control state; the element ram is not cleared
// the receiver cannot stall: a new command may be taken in the strobe cycle itself

module array_list_engine #(
    parameter int CAPACITY  = 64,
    parameter int ELEM_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_kind,
    input  logic [6:0]            i_position,
    input  logic [31:0]           i_value,
    output logic                  o_strobe,
    output alc_pkg::t_status      o_status,
    output logic [31:0]           o_read_value,
    output logic [5:0]            o_found_position,
    output logic [6:0]            o_count_after
);

    import alc_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    // common width for comparing a position with the length
    localparam int CW = (LW > POS_BITS) ? LW : POS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FIND,
        S_INS,
        S_DEL
    } t_state;

    // sequencer state
    t_state             r_state, n_state;
    logic [LW-1:0]      r_len, n_len;       // list length
    logic [LW-1:0]      r_ptr, n_ptr;       // next entry to read
    logic [LW-1:0]      r_pos, n_pos;       // latched request position
    logic               r_pv, n_pv;         // a ram read is in flight
    logic [AW-1:0]      r_paddr, n_paddr;   // address of the read in flight
    logic [ELEM_BITS-1:0] r_val, n_val;     // latched request value

    // result register
    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [ELEM_BITS-1:0] r_rd, n_rd;
    logic [AW-1:0]      r_fpos, n_fpos;

    // ram port
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ELEM_BITS-1:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [ELEM_BITS-1:0] w_q;

    logic               w_accept;
    logic [CW-1:0]      w_pos_c;
    logic [CW-1:0]      w_len_c;
    logic               w_pos_in;           // position names a stored element
    logic [ELEM_BITS+VAL_BITS-1:0] w_val_ext;
    logic [ELEM_BITS-1:0] w_val;
    logic [LW-1:0]      w_ptr_dec;
    logic [LW-1:0]      w_len_dec;

    assign w_accept  = start && !busy;
    assign w_pos_c   = CW'(i_position);
    assign w_len_c   = CW'(r_len);
    assign w_pos_in  = w_pos_c < w_len_c;
    // value masked to the element width, zero above 32 bits
    assign w_val_ext = {{ELEM_BITS{1'b0}}, i_value};
    assign w_val     = w_val_ext[ELEM_BITS-1:0];
    assign w_ptr_dec = r_ptr - LW'(1);
    assign w_len_dec = r_len - LW'(1);

    alc_ram #(
        .W     (ELEM_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // read-modify-write sequencer
    // the shift loops read one entry and write it one place over in the next cycle;
    // the read and the write in any one cycle are always at least two entries
    // apart, so no forwarding is needed
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_ptr    = r_ptr;
        n_pos    = r_pos;
        n_pv     = 1'b0;
        n_paddr  = r_paddr;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_status = r_status;
        n_rd     = r_rd;
        n_fpos   = r_fpos;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_raddr  = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                w_raddr = w_pos_c[AW-1:0];
                if (w_accept) begin
                    n_val    = w_val;
                    n_pos    = w_pos_c[LW-1:0];
                    n_rd     = '0;
                    n_fpos   = '0;
                    n_status = ST_BADPOS;
                    unique case (i_kind)
                        K_READ: begin
                            if (w_pos_in) begin
                                n_state = S_READ;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        K_FIND: begin
                            if (r_len == '0) begin
                                n_status = ST_NOTFOUND;
                                n_strobe = 1'b1;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_FIND;
                            end
                        end
                        K_INSERT: begin
                            // full takes precedence over a bad position
                            if (r_len == LW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_strobe = 1'b1;
                            end else if (w_pos_c > w_len_c) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_ptr   = r_len;
                                n_state = S_INS;
                            end
                        end
                        K_DELETE: begin
                            if (w_pos_in) begin
                                n_ptr   = w_pos_c[LW-1:0];
                                n_state = S_DEL;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        K_REPLACE: begin
                            // written straight away, no read needed
                            if (w_pos_in) begin
                                w_we     = 1'b1;
                                w_waddr  = w_pos_c[AW-1:0];
                                w_wdata  = w_val;
                                n_status = ST_OK;
                            end
                            n_strobe = 1'b1;
                        end
                        default: begin
                            // unused kinds change nothing
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_rd     = w_q;
                n_status = ST_OK;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_FIND: begin
                w_raddr = r_ptr[AW-1:0];
                priority if (r_pv && w_q == r_val) begin
                    n_status = ST_OK;
                    n_fpos   = r_paddr;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_pv && LW'(r_paddr) == w_len_dec) begin
                    n_status = ST_NOTFOUND;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_ptr < r_len) begin
                    n_pv    = 1'b1;
                    n_paddr = r_ptr[AW-1:0];
                    n_ptr   = r_ptr + LW'(1);
                end else begin
                    n_pv = 1'b0;
                end
            end

            S_INS: begin
                // walk down from the top, moving each entry up one place
                w_raddr = w_ptr_dec[AW-1:0];
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = r_paddr + AW'(1);
                    w_wdata = w_q;
                end else if (r_ptr == r_pos) begin
                    w_we     = 1'b1;
                    w_waddr  = r_pos[AW-1:0];
                    w_wdata  = r_val;
                    n_len    = r_len + LW'(1);
                    n_status = ST_OK;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
                if (r_ptr > r_pos) begin
                    n_pv    = 1'b1;
                    n_paddr = w_ptr_dec[AW-1:0];
                    n_ptr   = w_ptr_dec;
                end
            end

            S_DEL: begin
                // first read captures the removed element, the rest move down
                w_raddr = r_ptr[AW-1:0];
                if (r_pv) begin
                    if (r_paddr == r_pos[AW-1:0]) begin
                        n_rd = w_q;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_paddr - AW'(1);
                        w_wdata = w_q;
                    end
                end
                if (r_ptr < r_len) begin
                    n_pv    = 1'b1;
                    n_paddr = r_ptr[AW-1:0];
                    n_ptr   = r_ptr + LW'(1);
                end else if (!r_pv) begin
                    n_len    = w_len_dec;
                    n_status = ST_OK;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_pv     <= n_pv;
            r_strobe <= n_strobe;
        end
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_paddr  <= n_paddr;
        r_val    <= n_val;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_fpos   <= n_fpos;
    end

    logic [ELEM_BITS+VAL_BITS-1:0] w_rd_ext;
    logic [AW+FPOS_BITS-1:0]       w_fpos_ext;
    logic [LW+POS_BITS-1:0]        w_cnt_ext;

    assign w_rd_ext   = {{VAL_BITS{1'b0}}, r_rd};
    assign w_fpos_ext = {{FPOS_BITS{1'b0}}, r_fpos};
    assign w_cnt_ext  = {{POS_BITS{1'b0}}, r_len};

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_read_value     = w_rd_ext[VAL_BITS-1:0];
    assign o_found_position = w_fpos_ext[FPOS_BITS-1:0];
    assign o_count_after    = w_cnt_ext[POS_BITS-1:0];

    // a result is only ever strobed once the sequencer is back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while busy");

    // every accepted command either answers at once or starts a walk
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_strobe || busy))
        else $error("accepted command neither answered nor started");

    // no result appears without a command behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_strobe)
        else $error("result without a command");

    // the length only changes together with a result transfer
    a_len_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_len)) |-> o_strobe)
        else $error("length changed without a result");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("length beyond capacity");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import alc_pkg::*;

    localparam int LIST_CAP    = 64;    // default depth of the block under test
    localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int TAIL_CYCLES = 80;    // idle tail after the last phase, longer than the longest walk
    localparam int MAX_GAP     = 60;    // cap on one idle stretch of the sender
    localparam int PHASE_ITEMS = 330;

    // kinds the block does not implement, answered as a bad position
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    typedef struct {
        t_status     status;
        logic [31:0] read_value;
        logic [5:0]  found_pos;
        logic [6:0]  count;
    } t_answer;

    // shadow copy of the list, plus the answers still owed by the block
    class list_shadow;
        logic [31:0] elems [LIST_CAP];
        int          list_len;
        t_answer     expected_answers [$];
        int          mismatches;
        int          requests;
        int          peak_len;
        int          status_tally [4];

        function new();
            list_len   = 0;
            mismatches = 0;
            requests   = 0;
            peak_len   = 0;
            foreach (status_tally[s]) status_tally[s] = 0;
            foreach (elems[e]) elems[e] = '0;
        endfunction

        // apply one accepted request to the shadow list and queue its answer
        function void take_request(logic [2:0] kind, logic [6:0] pos, logic [31:0] val);
            t_answer a;
            int      p;
            int      i;
            p            = int'(pos);
            a.status     = ST_OK;
            a.read_value = '0;
            a.found_pos  = '0;
            case (kind)
                K_READ: begin
                    if (p < list_len) a.read_value = elems[p];
                    else a.status = ST_BADPOS;
                end
                K_FIND: begin
                    a.status = ST_NOTFOUND;
                    for (i = 0; i < list_len; i++) begin
                        if (elems[i] == val) begin
                            a.status    = ST_OK;
                            a.found_pos = 6'(i);
                            break;
                        end
                    end
                end
                K_INSERT: begin
                    // a full list is refused before the position is looked at
                    if (list_len >= LIST_CAP) begin
                        a.status = ST_FULL;
                    end else if (p > list_len) begin
                        a.status = ST_BADPOS;
                    end else begin
                        for (i = list_len; i > p; i--) elems[i] = elems[i - 1];
                        elems[p] = val;
                        list_len++;
                    end
                end
                K_DELETE: begin
                    if (p < list_len) begin
                        a.read_value = elems[p];
                        for (i = p; i + 1 < list_len; i++) elems[i] = elems[i + 1];
                        list_len--;
                    end else begin
                        a.status = ST_BADPOS;
                    end
                end
                K_REPLACE: begin
                    if (p < list_len) elems[p] = val;
                    else a.status = ST_BADPOS;
                end
                default: a.status = ST_BADPOS;
            endcase
            a.count = 7'(list_len);
            if (list_len > peak_len) peak_len = list_len;
            requests++;
            expected_answers.push_back(a);
        endfunction

        // compare one strobed result with the oldest owed answer
        function void check_answer(t_status st, logic [31:0] rd, logic [5:0] fp,
                                   logic [6:0] cnt);
            t_answer a;
            if (expected_answers.size() == 0) begin
                $error("result strobed with no request outstanding");
                mismatches++;
                return;
            end
            a = expected_answers.pop_front();
            status_tally[int'(a.status)]++;
            if (st !== a.status) begin
                $error("status: expected %0d, got %0d", a.status, st);
                mismatches++;
            end
            if (rd !== a.read_value) begin
                $error("read_value: expected %h, got %h", a.read_value, rd);
                mismatches++;
            end
            if (fp !== a.found_pos) begin
                $error("found_position: expected %0d, got %0d", a.found_pos, fp);
                mismatches++;
            end
            if (cnt !== a.count) begin
                $error("count_after: expected %0d, got %0d", a.count, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic [2:0]  i_kind     = '0;
    logic [6:0]  i_position = '0;
    logic [31:0] i_value    = '0;
    logic        busy;
    logic        o_strobe;
    t_status     o_status;
    logic [31:0] o_read_value;
    logic [5:0]  o_found_position;
    logic [6:0]  o_count_after;

    list_shadow shadow;
    int         quiet_cycles = 0;

    // sender idle share per phase: none, heavy, none again (the receiver stall
    // phase collapses to this, as results cannot be held off), light
    int sender_idle_pct [4] = '{0, 87, 0, 18};

    array_list_engine uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_count_after    (o_count_after)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // results are only valid in their strobe cycle, so check them on that edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            shadow.check_answer(o_status, o_read_value, o_found_position, o_count_after);
        end
    end

    // watchdog: a stretch with no transfer on either side means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hold a command until the block takes it; start stays high on return so a
    // following command goes out back to back
    task automatic issue(input logic [2:0] kind, input logic [6:0] pos,
                         input logic [31:0] val);
        start      <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // the block is back at rest at this edge, so the transfer has happened
        shadow.take_request(kind, pos, val);
    endtask

    // sender idle for the given number of cycles, with junk on the payload to show it is ignored
    task automatic pause_sender(input int cycles);
        int c;
        start <= 1'b0;
        for (c = 0; c < cycles; c++) begin
            i_kind     <= 3'($urandom);
            i_position <= 7'($urandom);
            i_value    <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // sender holds off until every owed answer has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.expected_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        // a narrow pool gives duplicates, so find has to pick the lowest match
        if (r < 40) return 32'($urandom_range(7));
        if (r < 44) return '0;
        if (r < 48) return '1;
        if (r < 50) return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_find_value();
        if (shadow.list_len > 0 && $urandom_range(99) < 60) begin
            return shadow.elems[$urandom_range(shadow.list_len - 1)];
        end
        return pick_value();
    endfunction

    function automatic logic [2:0] pick_kind(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            case ($urandom_range(2))
                0:       return KIND_SPARE_LO;
                1:       return KIND_SPARE_MID;
                default: return KIND_SPARE_HI;
            endcase
        end
        if (filling) begin
            if (r < 63) return K_INSERT;
            if (r < 75) return K_FIND;
            if (r < 85) return K_READ;
            if (r < 93) return K_REPLACE;
            return K_DELETE;
        end
        if (r < 13) return K_INSERT;
        if (r < 25) return K_FIND;
        if (r < 35) return K_READ;
        if (r < 45) return K_REPLACE;
        return K_DELETE;
    endfunction

    // mostly legal positions, with the length itself and the capacity mixed in
    function automatic logic [6:0] pick_position(input logic [2:0] kind);
        int len;
        int r;
        len = shadow.list_len;
        r   = $urandom_range(99);
        if (r < 80) begin
            if (kind == K_INSERT) return 7'($urandom_range(len));
            return (len > 0) ? 7'($urandom_range(len - 1)) : '0;
        end
        if (r < 88) return 7'(len);
        if (r < 94) return 7'(LIST_CAP);
        return 7'($urandom_range(LIST_CAP));
    endfunction

    // edge cases on an empty and a short list
    task automatic run_directed();
        issue(K_READ,    7'd0,  32'h0);             // read of an empty list
        issue(K_FIND,    7'd0,  32'h0);             // find in an empty list
        issue(K_DELETE,  7'd0,  32'h0);             // delete from an empty list
        issue(K_REPLACE, 7'd0,  32'h1);             // replace in an empty list
        issue(K_INSERT,  7'd1,  32'h1);             // insert past the length
        issue(KIND_SPARE_LO,  7'd0, 32'hFFFF_FFFF); // unimplemented kinds
        issue(KIND_SPARE_MID, 7'd64, 32'h0);
        issue(KIND_SPARE_HI,  7'd127, 32'h1234_5678);
        issue(K_INSERT,  7'd0,  32'hFFFF_FFFF);
        issue(K_INSERT,  7'd0,  32'h0000_0000);     // insert at the front
        issue(K_INSERT,  7'd2,  32'hA5A5_A5A5);     // append at the length
        issue(K_INSERT,  7'd1,  32'h5A5A_5A5A);     // insert in the middle
        issue(K_INSERT,  7'd5,  32'h1);             // one past the length
        issue(K_INSERT,  7'd64, 32'h1);             // the capacity as a position
        issue(K_READ,    7'd64, 32'h0);
        issue(K_READ,    7'd4,  32'h0);             // read at the length
        issue(K_READ,    7'd3,  32'h0);
        issue(K_REPLACE, 7'd3,  32'h0);             // list now holds zero twice
        issue(K_FIND,    7'd0,  32'h0);             // lowest of two matches
        issue(K_FIND,    7'd0,  32'h1234_5678);     // no match
        issue(K_DELETE,  7'd1,  32'h0);             // delete from the middle
        issue(K_DELETE,  7'd2,  32'h0);             // delete the last element
        issue(K_REPLACE, 7'd4,  32'h7);             // replace past the length
        issue(K_FIND,    7'd0,  32'hFFFF_FFFF);
        issue(K_READ,    7'd0,  32'h0);
    endtask

    // random traffic that swings the list between empty and full, so the full
    // refusal and the longest shifts are reached in every phase
    task automatic run_random_phase(input int idle_pct, input int count);
        int          k;
        int          gap;
        bit          filling;
        logic [2:0]  kind;
        logic [6:0]  pos;
        logic [31:0] val;
        filling = 1'b1;
        for (k = 0; k < count; k++) begin
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
            if (gap > 0) pause_sender(gap);
            else if ($urandom_range(63) == 0) wait_drained();
            if (shadow.list_len == LIST_CAP && $urandom_range(4) == 0) filling = 1'b0;
            else if (shadow.list_len == 0 && $urandom_range(2) == 0) filling = 1'b1;
            kind = pick_kind(filling);
            pos  = pick_position(kind);
            val  = (kind == K_FIND) ? pick_find_value() : pick_value();
            issue(kind, pos, val);
        end
    endtask

    initial begin
        int ph;
        shadow = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();
        for (ph = 0; ph < 4; ph++) begin
            run_random_phase(sender_idle_pct[ph], PHASE_ITEMS);
            wait_drained();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests over 4 traffic phases: ok %0d, bad position %0d,",
                 shadow.requests, shadow.status_tally[ST_OK],
                 shadow.status_tally[ST_BADPOS]);
        $display("full %0d, not found %0d; list grew to %0d of %0d entries",
                 shadow.status_tally[ST_FULL], shadow.status_tally[ST_NOTFOUND],
                 shadow.peak_len, LIST_CAP);
        if (shadow.mismatches == 0 && shadow.expected_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
